@@ rtl/sv32ptw_pkg.sv @@
// Package for the Sv32 page table walker: item types, field codes, PTE bits,
// the walker state encoding and the PTE address helper.
// No dependencies.
package sv32ptw_pkg;

  // Input item commands
  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_PTE_RESP  = 1'b1;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Access types
  localparam logic [1:0] ACC_FETCH = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;
  localparam logic [1:0] ACC_RSVD  = 2'd3;

  // Privilege levels
  localparam logic [1:0] PRIV_USER    = 2'd0;
  localparam logic [1:0] PRIV_SUPER   = 2'd1;
  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  // PTE bit positions
  localparam int PTE_V = 0;
  localparam int PTE_R = 1;
  localparam int PTE_W = 2;
  localparam int PTE_X = 3;
  localparam int PTE_U = 4;
  localparam int PTE_A = 6;
  localparam int PTE_D = 7;

  typedef struct packed {
    logic        cmd;
    logic [31:0] vaddr;
    logic [1:0]  access_type;
    logic [1:0]  privilege;
    logic        mxr;
    logic        sum;
    logic        mprv;
    logic [1:0]  mpp;
    logic        satp_mode;
    logic [21:0] satp_ppn;
    logic [31:0] pte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic        fault;
    logic        unexpected;
  } out_item_t;

  // Classified item handed from front to back.
  // data holds the level-1 PTE address for a translate, the PTE word for a response.
  typedef struct packed {
    logic        cmd;
    logic        pass;
    logic [31:0] vaddr;
    logic [1:0]  acc;
    logic [1:0]  act_priv;
    logic        mxr;
    logic        sum;
    logic [31:0] data;
  } cls_item_t;

  typedef enum logic [1:0] {
    WALK_IDLE = 2'd0,
    WALK_L1   = 2'd1,
    WALK_L0   = 2'd2
  } walk_state_t;

  // PPN shifted by the page size plus VPN times four, truncated to 32 bits.
  // The low 12 bits of the base are zero, so the add is a concatenation.
  function automatic logic [31:0] pte_address(input logic [21:0] ppn, input logic [9:0] vpn);
    pte_address = {ppn[19:0], vpn, 2'b00};
  endfunction

endpackage

@@ rtl/sv32ptw_fifo.sv @@
// Small register queue used between the walker parts and at the result side.
// Depends on nothing; the item type is a type parameter.
module sv32ptw_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  output logic  full,
  input  logic  pop,
  output item_t rd_item,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  item_t           mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ rtl/sv32ptw_front.sv @@
// Front part of the walker: normalizes the access type, resolves the
// effective privilege and forms the level-1 PTE address. Uses sv32ptw_pkg.
module sv32ptw_front
  import sv32ptw_pkg::*;
(
  input  in_item_t  item,
  output cls_item_t cls
);

  logic [1:0] acc;
  logic [1:0] eff;

  always_comb begin
    // reserved access type behaves as a load
    acc = (item.access_type == ACC_RSVD) ? ACC_LOAD : item.access_type;
    eff = (acc != ACC_FETCH && item.mprv) ? item.mpp : item.privilege;

    cls.cmd      = item.cmd;
    cls.pass     = (eff == PRIV_MACHINE) || !item.satp_mode;
    cls.vaddr    = item.vaddr;
    cls.acc      = acc;
    cls.act_priv = eff;
    cls.mxr      = item.mxr;
    cls.sum      = item.sum;
    cls.data     = (item.cmd == CMD_TRANSLATE) ?
                   pte_address(item.satp_ppn, item.vaddr[31:22]) : item.pte;
  end

endmodule

@@ rtl/sv32ptw_back.sv @@
// Back part of the walker: holds the walk state and saved request context,
// checks each PTE and builds one result per item. Uses sv32ptw_pkg.
module sv32ptw_back
  import sv32ptw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cls_item_t q_item,
  output logic      q_pop,
  input  logic      res_full,
  output logic      res_push,
  output out_item_t res_item
);

  walk_state_t state_r, state_nxt;
  logic [31:0] saved_vaddr_r, saved_vaddr_nxt;
  logic [1:0]  saved_acc_r, saved_acc_nxt;
  logic [1:0]  saved_priv_r, saved_priv_nxt;
  logic        saved_mxr_r, saved_mxr_nxt;
  logic        saved_sum_r, saved_sum_nxt;

  logic        fire;
  logic [31:0] pte;
  logic        leaf;
  logic        bad_entry;
  logic        perm_fault;
  logic        level1;

  assign fire     = q_valid && !res_full;
  assign q_pop    = fire;
  assign res_push = fire;
  assign pte      = q_item.data;
  assign level1   = (state_r == WALK_L1);
  assign leaf     = pte[PTE_R] || pte[PTE_X];
  assign bad_entry = !pte[PTE_V] || (!pte[PTE_R] && pte[PTE_W]);

  always_comb begin
    perm_fault = 1'b0;
    if (level1 && pte[19:10] != 10'd0) perm_fault = 1'b1;  // misaligned superpage
    if (saved_acc_r == ACC_FETCH && !pte[PTE_X]) perm_fault = 1'b1;
    if (saved_acc_r == ACC_LOAD && !pte[PTE_R] && !(saved_mxr_r && pte[PTE_X]))
      perm_fault = 1'b1;
    if (saved_acc_r == ACC_STORE && !pte[PTE_W]) perm_fault = 1'b1;
    if (saved_priv_r == PRIV_USER && !pte[PTE_U]) perm_fault = 1'b1;
    if (saved_priv_r == PRIV_SUPER && pte[PTE_U] && !saved_sum_r) perm_fault = 1'b1;
    if (!pte[PTE_A]) perm_fault = 1'b1;
    if (saved_acc_r == ACC_STORE && !pte[PTE_D]) perm_fault = 1'b1;
  end

  always_comb begin
    state_nxt       = state_r;
    saved_vaddr_nxt = saved_vaddr_r;
    saved_acc_nxt   = saved_acc_r;
    saved_priv_nxt  = saved_priv_r;
    saved_mxr_nxt   = saved_mxr_r;
    saved_sum_nxt   = saved_sum_r;
    res_item.kind       = KIND_DONE;
    res_item.addr       = '0;
    res_item.fault      = 1'b1;
    res_item.unexpected = 1'b0;

    case (q_item.cmd)
      CMD_TRANSLATE: begin
        if (state_r != WALK_IDLE) begin
          res_item.unexpected = 1'b1;
        end else if (q_item.pass) begin
          res_item.addr  = q_item.vaddr;
          res_item.fault = 1'b0;
        end else begin
          res_item.kind   = KIND_READ;
          res_item.addr   = q_item.data;
          res_item.fault  = 1'b0;
          state_nxt       = WALK_L1;
          saved_vaddr_nxt = q_item.vaddr;
          saved_acc_nxt   = q_item.acc;
          saved_priv_nxt  = q_item.act_priv;
          saved_mxr_nxt   = q_item.mxr;
          saved_sum_nxt   = q_item.sum;
        end
      end
      CMD_PTE_RESP: begin
        if (state_r == WALK_IDLE) begin
          res_item.unexpected = 1'b1;
        end else if (bad_entry) begin
          state_nxt = WALK_IDLE;
        end else if (leaf) begin
          state_nxt = WALK_IDLE;
          if (!perm_fault) begin
            res_item.fault = 1'b0;
            res_item.addr  = level1 ? {pte[29:20], saved_vaddr_r[21:0]}
                                    : {pte[29:10], saved_vaddr_r[11:0]};
          end
        end else if (!level1) begin
          // pointer at the last level
          state_nxt = WALK_IDLE;
        end else begin
          res_item.kind  = KIND_READ;
          res_item.fault = 1'b0;
          res_item.addr  = pte_address(pte[31:10], saved_vaddr_r[21:12]);
          state_nxt      = WALK_L0;
        end
      end
      default: begin
        res_item.unexpected = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= WALK_IDLE;
      saved_vaddr_r <= '0;
      saved_acc_r   <= '0;
      saved_priv_r  <= '0;
      saved_mxr_r   <= 1'b0;
      saved_sum_r   <= 1'b0;
    end else if (fire) begin
      state_r       <= state_nxt;
      saved_vaddr_r <= saved_vaddr_nxt;
      saved_acc_r   <= saved_acc_nxt;
      saved_priv_r  <= saved_priv_nxt;
      saved_mxr_r   <= saved_mxr_nxt;
      saved_sum_r   <= saved_sum_nxt;
    end
  end

endmodule

@@ rtl/sv32_page_table_walker_unit.sv @@
// Sv32 page table walker, top level: front classifier, command queue,
// back walker and result queue. Uses sv32ptw_pkg and the modules above.
//
// Usage:
//   Input queue: drive in_item and raise in_push; a transaction is taken at a
//   clock edge where in_push is high and in_full is low. An item is either a
//   translate request or the PTE word answering an earlier read request.
//   Result queue: while out_empty is low, out_item holds the oldest result;
//   raise out_pop to take it. Every input item yields exactly one result:
//   a PTE read request, or a finished translation (address or fault).
//   Path: an item taken is registered in the command queue; the back part then
//   writes its result into the result queue, from which it can be popped.
//   Throughput: one item per cycle while the result queue is not full, set by
//   the combinational check and address logic in the back part; both queues move one entry per cycle.
//   Reset (rst_n low, synchronous): both queues empty, walker idle.
//   When the receiver stalls, results collect in the result queue, then the
//   command queue fills and in_full rises until out_pop frees an entry.
//   Parameters: CMD_DEPTH and RES_DEPTH, queue depths, two or more.
module sv32_page_table_walker_unit
  import sv32ptw_pkg::*;
#(
  parameter int CMD_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  input  logic      out_pop,
  output out_item_t out_item,
  output logic      out_empty
);

  cls_item_t cls_item;
  cls_item_t q_item;
  logic      q_empty;
  logic      q_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res_item;

  sv32ptw_front u_front (
    .item (in_item),
    .cls  (cls_item)
  );

  sv32ptw_fifo #(
    .item_t (cls_item_t),
    .DEPTH  (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_item (cls_item),
    .full    (in_full),
    .pop     (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  sv32ptw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (!q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  sv32ptw_fifo #(
    .item_t (out_item_t),
    .DEPTH  (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_item (res_item),
    .full    (res_full),
    .pop     (out_pop),
    .rd_item (out_item),
    .empty   (out_empty)
  );

endmodule

@@ rtl/sv32ptw_checker.sv @@
// Port-level checks for the Sv32 page table walker, bound to the top level.
// Uses sv32ptw_pkg.
module sv32ptw_checker
  import sv32ptw_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_pop,
  input out_item_t out_item,
  input logic      out_empty
);

  // reset drains both sides
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("stalled result changed");

  // a faulting translation reports no address
  a_fault_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.fault) |-> (out_item.kind == KIND_DONE && out_item.addr == '0))
    else $error("fault result with address");

  // read requests carry no fault flags
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.kind == KIND_READ) |-> (!out_item.fault && !out_item.unexpected))
    else $error("read request flagged");

  // an out-of-order transaction always finishes as a fault
  a_unexp_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.unexpected) |-> out_item.fault)
    else $error("unexpected without fault");

endmodule

bind sv32_page_table_walker_unit sv32ptw_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_item  (out_item),
  .out_empty (out_empty)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sv32_page_table_walker_unit: directed and random
// translate requests and PTE responses through both queues, checked against an
// in-bench Sv32 walk predictor. Depends on sv32ptw_pkg.
module testbench;
  import sv32ptw_pkg::*;

  localparam logic [7:0] F_V = 8'(1 << PTE_V);
  localparam logic [7:0] F_R = 8'(1 << PTE_R);
  localparam logic [7:0] F_W = 8'(1 << PTE_W);
  localparam logic [7:0] F_X = 8'(1 << PTE_X);
  localparam logic [7:0] F_U = 8'(1 << PTE_U);
  localparam logic [7:0] F_A = 8'(1 << PTE_A);
  localparam logic [7:0] F_D = 8'(1 << PTE_D);
  localparam logic [1:0] PRIV_RSVD = 2'd2;
  localparam int HOLD_OFF_CYCLES = 300;

  class walk_scoreboard;
    out_item_t expected_q[$];
    int errors;
    logic walk_active;
    logic at_root_level;
    logic [31:0] walk_va;
    logic [1:0] walk_acc;
    logic [1:0] walk_priv;
    logic walk_mxr;
    logic walk_sum_bit;

    function new();
      errors = 0;
      walk_active = 1'b0;
      at_root_level = 1'b0;
      walk_va = '0;
      walk_acc = ACC_FETCH;
      walk_priv = PRIV_USER;
      walk_mxr = 1'b0;
      walk_sum_bit = 1'b0;
    endfunction

    function automatic logic [31:0] entry_addr(logic [21:0] ppn, logic [9:0] vpn);
      logic [33:0] full_addr;
      full_addr = {ppn, 12'h000} + {22'h0, vpn, 2'b00};
      return full_addr[31:0];
    endfunction

    function automatic out_item_t done_item(logic [31:0] addr, logic flt, logic unexp);
      out_item_t r;
      r.kind = KIND_DONE;
      r.addr = addr;
      r.fault = flt;
      r.unexpected = unexp;
      return r;
    endfunction

    function automatic out_item_t read_item(logic [31:0] addr);
      out_item_t r;
      r.kind = KIND_READ;
      r.addr = addr;
      r.fault = 1'b0;
      r.unexpected = 1'b0;
      return r;
    endfunction

    function automatic out_item_t page_fault();
      walk_active = 1'b0;
      return done_item(32'h0, 1'b1, 1'b0);
    endfunction

    // Advance the walk by one item and return the result it causes.
    function automatic out_item_t walk_step(in_item_t it);
      logic [1:0] acc;
      logic [1:0] eff;
      logic [31:0] p;
      logic [31:0] base;
      acc = (it.access_type == ACC_RSVD) ? ACC_LOAD : it.access_type;
      p = it.pte;
      if (it.cmd == CMD_TRANSLATE) begin
        if (walk_active) return done_item(32'h0, 1'b1, 1'b1);
        eff = (acc != ACC_FETCH && it.mprv) ? it.mpp : it.privilege;
        if (eff == PRIV_MACHINE || !it.satp_mode) return done_item(it.vaddr, 1'b0, 1'b0);
        walk_active = 1'b1;
        at_root_level = 1'b1;
        walk_va = it.vaddr;
        walk_acc = acc;
        walk_priv = eff;
        walk_mxr = it.mxr;
        walk_sum_bit = it.sum;
        return read_item(entry_addr(it.satp_ppn, it.vaddr[31:22]));
      end
      if (!walk_active) return done_item(32'h0, 1'b1, 1'b1);
      if (!p[PTE_V] || (!p[PTE_R] && p[PTE_W])) return page_fault();
      if (p[PTE_R] || p[PTE_X]) begin
        if (at_root_level && p[19:10] != 10'h0) return page_fault();
        if (walk_acc == ACC_FETCH && !p[PTE_X]) return page_fault();
        if (walk_acc == ACC_LOAD && !p[PTE_R] && !(walk_mxr && p[PTE_X])) return page_fault();
        if (walk_acc == ACC_STORE && !p[PTE_W]) return page_fault();
        if (walk_priv == PRIV_USER && !p[PTE_U]) return page_fault();
        if (walk_priv == PRIV_SUPER && p[PTE_U] && !walk_sum_bit) return page_fault();
        if (!p[PTE_A]) return page_fault();
        if (walk_acc == ACC_STORE && !p[PTE_D]) return page_fault();
        base = {p[29:10], 12'h000};
        walk_active = 1'b0;
        if (at_root_level) return done_item({base[31:22], walk_va[21:0]}, 1'b0, 1'b0);
        return done_item({base[31:12], walk_va[11:0]}, 1'b0, 1'b0);
      end
      if (!at_root_level) return page_fault();
      at_root_level = 1'b0;
      return read_item(entry_addr(p[31:10], walk_va[21:12]));
    endfunction

    function void note_item(in_item_t it);
      expected_q.push_back(walk_step(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending: kind %0d addr %h", got.kind, got.addr);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.kind !== exp_item.kind) begin
        $error("kind: expected %0d, actual %0d", exp_item.kind, got.kind);
        errors++;
      end
      if (got.addr !== exp_item.addr) begin
        $error("addr: expected %h, actual %h", exp_item.addr, got.addr);
        errors++;
      end
      if (got.fault !== exp_item.fault) begin
        $error("fault: expected %0d, actual %0d", exp_item.fault, got.fault);
        errors++;
      end
      if (got.unexpected !== exp_item.unexpected) begin
        $error("unexpected: expected %0d, actual %0d", exp_item.unexpected, got.unexpected);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_push;
  in_item_t in_item;
  logic in_full;
  logic out_pop;
  out_item_t out_item;
  logic out_empty;

  walk_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  sv32_page_table_walker_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_item(in_item),
    .in_full(in_full),
    .out_pop(out_pop),
    .out_item(out_item),
    .out_empty(out_empty)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic in_item_t translate(logic [31:0] va, logic [1:0] acc, logic [1:0] priv,
                                         logic mxr, logic sum, logic mprv, logic [1:0] mpp,
                                         logic mode, logic [21:0] ppn);
    in_item_t it;
    it = '0;
    it.cmd = CMD_TRANSLATE;
    it.vaddr = va;
    it.access_type = acc;
    it.privilege = priv;
    it.mxr = mxr;
    it.sum = sum;
    it.mprv = mprv;
    it.mpp = mpp;
    it.satp_mode = mode;
    it.satp_ppn = ppn;
    return it;
  endfunction

  function automatic in_item_t pte_resp(logic [21:0] ppn, logic [7:0] flags);
    in_item_t it;
    it = '0;
    it.cmd = CMD_PTE_RESP;
    it.pte = {ppn, 2'b00, flags};
    return it;
  endfunction

  // Shape a PTE so that most walks get past the permission checks.
  function automatic logic [31:0] shaped_pte();
    logic [31:0] p;
    p = $urandom;
    p[PTE_V] = ($urandom_range(19) != 0);
    p[PTE_A] = ($urandom_range(9) != 0);
    p[PTE_D] = ($urandom_range(5) != 0);
    if ($urandom_range(99) < 15) return p;
    if (sb.at_root_level && $urandom_range(1)) begin
      p[PTE_R] = 1'b0;
      p[PTE_W] = 1'b0;
      p[PTE_X] = 1'b0;
      return p;
    end
    p[PTE_W] = 1'b0;
    case (sb.walk_acc)
      ACC_FETCH: p[PTE_X] = 1'b1;
      ACC_LOAD: begin
        if (sb.walk_mxr && $urandom_range(1)) begin
          p[PTE_X] = 1'b1;
        end else begin
          p[PTE_R] = 1'b1;
        end
      end
      default: begin
        p[PTE_R] = 1'b1;
        p[PTE_W] = 1'b1;
      end
    endcase
    if (sb.walk_priv == PRIV_USER) begin
      p[PTE_U] = 1'b1;
    end else if (sb.walk_priv == PRIV_SUPER && !sb.walk_sum_bit) begin
      p[PTE_U] = 1'b0;
    end
    if (sb.at_root_level && $urandom_range(4) != 0) p[19:10] = 10'h0;
    return p;
  endfunction

  function automatic in_item_t next_random_item();
    in_item_t it;
    it.cmd = 1'($urandom_range(1));
    it.vaddr = $urandom;
    it.access_type = 2'($urandom_range(3));
    it.privilege = 2'($urandom_range(3));
    it.mxr = 1'($urandom_range(1));
    it.sum = 1'($urandom_range(1));
    it.mprv = 1'($urandom_range(1));
    it.mpp = 2'($urandom_range(3));
    it.satp_mode = 1'($urandom_range(1));
    it.satp_ppn = 22'($urandom);
    it.pte = $urandom;
    if ($urandom_range(99) < 10) return it;
    if (!sb.walk_active) begin
      it.cmd = CMD_TRANSLATE;
      it.satp_mode = ($urandom_range(9) != 0);
      it.mprv = ($urandom_range(3) == 0);
      if ($urandom_range(9) < 8) it.privilege = 2'($urandom_range(1));
      if ($urandom_range(9) != 0) it.access_type = 2'($urandom_range(2));
    end else begin
      it.cmd = CMD_PTE_RESP;
      it.pte = shaped_pte();
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_item(it);
  endtask

  // Result side: pop at random, or hold off for a long stretch on request.
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_pop <= !($urandom_range(99) < recv_stall_pct);
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_result(out_item);
    end
  end

  initial begin
    in_item_t directed_q[$];
    int idle_by_phase[4];
    int stall_by_phase[4];
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_item <= '0;
    out_pop <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Passthrough: machine mode, bare satp, MPRV with MPP machine
    directed_q.push_back(translate(32'hFFFF_FFFF, ACC_LOAD, PRIV_MACHINE, 1, 1, 0,
                                   PRIV_USER, 1, 22'h3FFFFF));
    directed_q.push_back(translate(32'h0, ACC_FETCH, PRIV_USER, 0, 0, 0, PRIV_USER, 0, 22'h0));
    directed_q.push_back(translate(32'h1234_5678, ACC_STORE, PRIV_USER, 0, 0, 1,
                                   PRIV_MACHINE, 1, 22'h12345));
    // Fetch ignores MPRV; two-level walk with truncated physical address
    directed_q.push_back(translate(32'hFFFF_F123, ACC_FETCH, PRIV_USER, 0, 0, 1,
                                   PRIV_MACHINE, 1, 22'h3FFFFF));
    directed_q.push_back(pte_resp(22'h00ABC, F_V));
    directed_q.push_back(pte_resp(22'h3FFFFF, F_V | F_X | F_U | F_A));
    // PTE response while idle
    directed_q.push_back(pte_resp(22'h3FFFFF, 8'hFF));
    // Translate while busy, then an invalid PTE
    directed_q.push_back(translate(32'h8000_0000, ACC_STORE, PRIV_SUPER, 0, 0, 0,
                                   PRIV_USER, 1, 22'h0));
    directed_q.push_back(translate(32'h0000_1000, ACC_LOAD, PRIV_MACHINE, 0, 0, 0,
                                   PRIV_USER, 0, 22'h0));
    directed_q.push_back(pte_resp(22'h0, 8'h00));
    // Reserved access type as load, privilege 2, misaligned superpage
    directed_q.push_back(translate(32'h7FFF_FFFF, ACC_RSVD, PRIV_RSVD, 0, 0, 0,
                                   PRIV_USER, 1, 22'h000001));
    directed_q.push_back(pte_resp(22'h00401, F_V | F_R | F_A));
    // MXR load from an execute-only user superpage
    directed_q.push_back(translate(32'h0040_1ABC, ACC_LOAD, PRIV_USER, 1, 0, 0,
                                   PRIV_USER, 1, 22'h2AAAA));
    directed_q.push_back(pte_resp(22'h3FFC00, F_V | F_X | F_U | F_A));
    // Write without read
    directed_q.push_back(translate(32'h0123_4567, ACC_STORE, PRIV_SUPER, 0, 0, 0,
                                   PRIV_USER, 1, 22'h00100));
    directed_q.push_back(pte_resp(22'h0, F_V | F_W | F_A | F_D));
    // Non-leaf at level 0
    directed_q.push_back(translate(32'hABCD_EF01, ACC_LOAD, PRIV_SUPER, 0, 0, 0,
                                   PRIV_USER, 1, 22'h00200));
    directed_q.push_back(pte_resp(22'h00300, F_V));
    directed_q.push_back(pte_resp(22'h00400, F_V));
    // Store with dirty clear on a SUM-reachable user page
    directed_q.push_back(translate(32'h0080_0000, ACC_STORE, PRIV_SUPER, 0, 1, 0,
                                   PRIV_USER, 1, 22'h00010));
    directed_q.push_back(pte_resp(22'h00400, F_V | F_R | F_W | F_U | F_A));
    // Supervisor load of a user page with SUM set, two levels
    directed_q.push_back(translate(32'h5555_5555, ACC_LOAD, PRIV_SUPER, 0, 1, 0,
                                   PRIV_USER, 1, 22'h15555));
    directed_q.push_back(pte_resp(22'h2AAAA, F_V));
    directed_q.push_back(pte_resp(22'h155555, F_V | F_R | F_U | F_A));
    // Accessed clear
    directed_q.push_back(translate(32'h0000_0FFF, ACC_LOAD, PRIV_USER, 0, 0, 0,
                                   PRIV_USER, 1, 22'h0));
    directed_q.push_back(pte_resp(22'h0, F_V | F_R | F_U));
    foreach (directed_q[i]) send_item(directed_q[i]);

    idle_by_phase = '{0, 71, 0, 18};
    stall_by_phase = '{0, 0, 71, 18};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      repeat (388) send_item(next_random_item());
    end

    // Back-pressure: receiver holds off while the sender keeps offering
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    repeat (40) send_item(next_random_item());
    in_push <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
